### hdl/integer_to_ascii_converter_core_defines.svh
// Assertion macros for the RTL, included by itoa_ctrl.
`ifndef INTEGER_TO_ASCII_CONVERTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ITOA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("itoa assertion failed");
`define ITOA_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("itoa forbidden condition seen");
`else
`define ITOA_ASSERT(label, clk, rst_n, prop)
`define ITOA_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### hdl/itoa_pkg.sv
package itoa_pkg;

    localparam int unsigned NUM_DIGITS = 20;
    localparam int unsigned DIGITS_W   = 4 * NUM_DIGITS;
    localparam int unsigned DCNT_W     = 5;
    localparam int unsigned BCNT_W     = 6;

    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;

    localparam logic [6:0] ASC_MINUS = 7'h2d;
    localparam logic [6:0] ASC_ZERO  = 7'h30;
    localparam logic [6:0] ASC_X     = 7'h78;
    localparam logic [6:0] ASC_LA    = 7'h61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CONV,
        ST_SIGN,
        ST_PRE0,
        ST_PREX,
        ST_SKIP,
        ST_DIGIT
    } itoa_state_t;

    typedef enum logic [1:0] {
        SEL_MINUS,
        SEL_ZERO,
        SEL_X,
        SEL_DIGIT
    } itoa_sel_t;

    typedef struct packed {
        logic      load;
        logic      conv;
        logic      shift;
        logic      emit;
        itoa_sel_t sel;
    } itoa_cmd_t;

    typedef struct packed {
        logic neg;
        logic hex;
        logic conv_done;
        logic lead_zero;
        logic last_digit;
        logic out_free;
    } itoa_sts_t;

    function automatic logic [6:0] digit_ascii(input logic [3:0] d);
        logic [6:0] r;
        if (d < 4'd10)
        begin
            r = ASC_ZERO + {3'b000, d};
        end
        else
        begin
            r = ASC_LA + {3'b000, d} - 7'd10;
        end
        return r;
    endfunction

endpackage

### hdl/integer_to_ascii_converter_core.sv
// Channel  Handshake              Payload                  Notes
// req      req_valid/req_ready    action, is_long, value   one number per request
// txt      txt_valid/txt_ready    char_out, last           one ASCII character each
//
// One request at a time: req_ready is high only in the idle state, so each
// request is taken in the idle state, passes a set-up state, then the steps below.
// Decimal: a shift-add-3 step per magnitude bit, up to 19 leading zeros skipped,
// then one character per cycle while the output is free, '-' first. Hex: "0x",
// 4 to 19 leading zeros skipped, then the digits. A low txt_ready holds the
// character register and stalls the sequencer at its next character; no data is lost.
// Reset (rst_n, asynchronous, active low) clears the sequencer and txt_valid.
module integer_to_ascii_converter_core
    import itoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  action,
    input  logic        is_long,
    input  logic [63:0] value,
    output logic        txt_valid,
    input  logic        txt_ready,
    output logic [6:0]  char_out,
    output logic        last
);

    // command and status between sequencer and datapath
    itoa_cmd_t cmd;
    itoa_sts_t sts;

    // sequencer: request intake, conversion steps, prefix and digit emission
    itoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: magnitude, BCD/hex digit register, character output register
    itoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .is_long   (is_long),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .txt_valid (txt_valid),
        .txt_ready (txt_ready),
        .char_out  (char_out),
        .last      (last)
    );

endmodule

### hdl/itoa_dp.sv
module itoa_dp
    import itoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  action,
    input  logic        is_long,
    input  logic [63:0] value,
    input  itoa_cmd_t   cmd,
    output itoa_sts_t   sts,
    output logic        txt_valid,
    input  logic        txt_ready,
    output logic [6:0]  char_out,
    output logic        last
);

    logic [63:0]         mag_reg, mag_next;
    logic [DIGITS_W-1:0] dig_reg, dig_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [BCNT_W-1:0]   bcnt_reg, bcnt_next;
    logic                neg_reg, hex_reg;
    logic                vld_reg, vld_next;
    logic [6:0]          chr_reg;
    logic                last_reg;

    logic [63:0]         ext;
    logic                is_neg;
    logic [63:0]         mag_in;
    logic [DIGITS_W-1:0] adj;
    logic [6:0]          chr_sel;

    // operand extension and magnitude
    always_comb
    begin
        if (is_long)
        begin
            ext = value;
        end
        else if (action == MODE_SDEC)
        begin
            ext = {{32{value[31]}}, value[31:0]};
        end
        else
        begin
            ext = {32'd0, value[31:0]};
        end
        is_neg = (action == MODE_SDEC) && ext[63];
        mag_in = is_neg ? (~ext + 64'd1) : ext;
    end

    // shift-add-3 digit correction
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                         : dig_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_MINUS: chr_sel = ASC_MINUS;
            SEL_ZERO:  chr_sel = ASC_ZERO;
            SEL_X:     chr_sel = ASC_X;
            SEL_DIGIT: chr_sel = digit_ascii(dig_reg[DIGITS_W-1 -: 4]);
            default:   chr_sel = ASC_ZERO;
        endcase
    end

    always_comb
    begin
        mag_next  = mag_reg;
        dig_next  = dig_reg;
        dcnt_next = dcnt_reg;
        bcnt_next = bcnt_reg;
        if (cmd.load)
        begin
            mag_next  = mag_in;
            dig_next  = action[1] ? {{(DIGITS_W-64){1'b0}}, mag_in} : '0;
            dcnt_next = DCNT_W'(NUM_DIGITS);
            bcnt_next = '0;
        end
        else if (cmd.conv)
        begin
            mag_next  = {mag_reg[62:0], 1'b0};
            dig_next  = {adj[DIGITS_W-2:0], mag_reg[63]};
            bcnt_next = bcnt_reg + 1'b1;
        end
        else if (cmd.shift)
        begin
            dig_next  = {dig_reg[DIGITS_W-5:0], 4'd0};
            dcnt_next = dcnt_reg - 1'b1;
        end

        if (cmd.emit)
        begin
            vld_next = 1'b1;
        end
        else if (txt_ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        dig_reg  <= dig_next;
        dcnt_reg <= dcnt_next;
        bcnt_reg <= bcnt_next;
        if (cmd.load)
        begin
            neg_reg <= is_neg;
            hex_reg <= action[1];
        end
        if (cmd.emit)
        begin
            chr_reg  <= chr_sel;
            last_reg <= (cmd.sel == SEL_DIGIT) && (dcnt_reg == DCNT_W'(1));
        end
    end

    assign sts.neg        = neg_reg;
    assign sts.hex        = hex_reg;
    assign sts.conv_done  = (bcnt_reg == {BCNT_W{1'b1}});
    assign sts.lead_zero  = (dig_reg[DIGITS_W-1 -: 4] == 4'd0) && (dcnt_reg > DCNT_W'(1));
    assign sts.last_digit = (dcnt_reg == DCNT_W'(1));
    assign sts.out_free   = !vld_reg || txt_ready;

    assign txt_valid = vld_reg;
    assign char_out  = chr_reg;
    assign last      = last_reg;

endmodule

### hdl/itoa_ctrl.sv
`include "integer_to_ascii_converter_core_defines.svh"

module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  itoa_sts_t sts,
    output itoa_cmd_t cmd
);

    itoa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = sts.hex ? ST_PRE0 : ST_CONV;
            end
            ST_CONV:
            begin
                if (sts.conv_done)
                begin
                    state_next = sts.neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_PRE0:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_PREX;
                end
            end
            ST_PREX:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!sts.lead_zero)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (sts.out_free && sts.last_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        cmd.sel   = SEL_DIGIT;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_MINUS;
            end
            ST_PRE0:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_ZERO;
            end
            ST_PREX:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_X;
            end
            ST_SKIP:
            begin
                cmd.shift = sts.lead_zero;
            end
            ST_DIGIT:
            begin
                cmd.emit  = sts.out_free;
                cmd.shift = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `ITOA_ASSERT_NEVER(a_emit_blocked, clk, rst_n, cmd.emit && !sts.out_free)
    `ITOA_ASSERT(a_load_start, clk, rst_n, cmd.load |=> state_reg == ST_START)
    `ITOA_ASSERT(a_last_idle, clk, rst_n, (cmd.emit && sts.last_digit) |=> state_reg == ST_IDLE)
    `ITOA_ASSERT(a_conv_exit, clk, rst_n, (state_reg == ST_CONV && sts.conv_done) |=> state_reg != ST_CONV)

endmodule

### verif/tb_integer_to_ascii_converter_core.sv
// Testbench for the integer to ASCII converter.
// Each request (mode, width flag, 64-bit value) is turned into the expected
// character stream by a local predictor. The characters are queued and then
// compared one by one, in order, with what comes out of the txt channel.
module tb_integer_to_ascii_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;

    // The package names only the two decimal modes. Code 3 is spare and
    // behaves as hex.
    localparam logic [1:0] MODE_HEX   = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Digit glyphs, most significant byte first: glyph d sits in byte 15-d.
    localparam logic [127:0] GLYPHS = "0123456789abcdef";

    localparam int CYCLE_LIMIT = 1_000_000;
    // Worst case is a full decimal conversion plus skip and 20 characters.
    localparam int END_GUARD   = 200;

    typedef struct packed {
        logic [6:0] ch;
        logic       fin;
    } text_char_t;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Request channel: all inputs start at known values.
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  action    = MODE_SDEC;
    logic        is_long   = 1'b0;
    logic [63:0] value     = '0;

    // Text channel.
    logic        txt_valid;
    logic        txt_ready = 1'b0;
    logic [6:0]  char_out;
    logic        last;

    integer_to_ascii_converter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .action    (action),
        .is_long   (is_long),
        .value     (value),
        .txt_valid (txt_valid),
        .txt_ready (txt_ready),
        .char_out  (char_out),
        .last      (last)
    );

    // Characters still owed by the block, oldest first.
    text_char_t expected_text[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int requests_sent = 0;
    int chars_checked = 0;
    int cycle_count = 0;
    int mode_count[4] = '{0, 0, 0, 0};

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Text predictor: character stream for one request.
    function automatic void predict_text(input logic [1:0] act, input logic lng,
                                         input logic [63:0] val);
        logic [63:0] bits;
        logic [63:0] mag;
        logic [63:0] radix;
        logic [3:0]  d;
        text_char_t  line[$];
        text_char_t  c;

        c.fin = 1'b0;
        if (act == MODE_SDEC)
        begin
            // Narrow signed: sign-extend from bit 31.
            bits  = lng ? val : {{32{val[31]}}, val[31:0]};
            radix = 64'd10;
            if (bits[63])
            begin
                c.ch = ASC_MINUS;
                line.push_back(c);
                // Two's complement magnitude; the most negative value wraps
                // to itself and reads correctly as unsigned.
                mag = ~bits + 64'd1;
            end
            else
            begin
                mag = bits;
            end
        end
        else
        begin
            mag = lng ? val : {32'd0, val[31:0]};
            if (act == MODE_UDEC)
            begin
                radix = 64'd10;
            end
            else
            begin
                // Hex, including the spare mode code.
                radix = 64'd16;
                c.ch = ASC_ZERO;
                line.push_back(c);
                c.ch = ASC_X;
                line.push_back(c);
            end
        end

        // Digits are found least significant first, so insert at the front
        // of the digit section.
        begin
            text_char_t digits[$];
            do
            begin
                d    = 4'(mag % radix);
                c.ch = GLYPHS[8 * (15 - d) +: 7];
                digits.push_front(c);
                mag  = mag / radix;
            end
            while (mag != 64'd0);
            foreach (digits[i])
                line.push_back(digits[i]);
        end

        line[line.size() - 1].fin = 1'b1;
        foreach (line[i])
            expected_text.push_back(line[i]);
    endfunction

    // Send one request. Valid stays high until the handshake completes;
    // idle gaps only fall between requests.
    task automatic send_request(input logic [1:0] act, input logic lng,
                                input logic [63:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= act;
        is_long   <= lng;
        value     <= val;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_text(act, lng, val);
        requests_sent++;
        mode_count[act]++;
    endtask

    // Drop valid and hold off until every owed character has come back.
    task automatic drain_text();
        req_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    // Shaped random values: digit-count boundaries, sign boundaries, small
    // numbers and full-range noise.
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] p;
        int k;

        v = {$urandom, $urandom};
        p = 64'd1;
        case ($urandom_range(7))
            0:
            begin
                v = 64'($urandom_range(99));
            end
            1:
            begin
                // Around a power of ten: digit count changes here.
                k = $urandom_range(19);
                repeat (k) p = p * 64'd10;
                v = p + 64'($urandom_range(2)) - 64'd1;
            end
            2:
            begin
                // Around a power of sixteen.
                p = 64'd1 << (4 * $urandom_range(15));
                v = p - 64'($urandom_range(1));
            end
            3:
            begin
                // Small negative numbers in 64-bit two's complement.
                v = -64'($urandom_range(1000));
            end
            4:
            begin
                // Near the 32-bit sign boundary, upper half random.
                v[31:0] = 32'h8000_0000 - 32'($urandom_range(2));
            end
            5:
            begin
                // Near the 64-bit sign boundary.
                v = 64'h8000_0000_0000_0000 - 64'($urandom_range(2));
            end
            6:
            begin
                v = v >> $urandom_range(63);
            end
            default:
            begin
                v = v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_mode();
        logic [1:0] m;
        // Spare code now and then; the three real modes otherwise.
        if ($urandom_range(19) == 0)
            m = MODE_SPARE;
        else
            m = 2'($urandom_range(2));
        return m;
    endfunction

    // Edge values for every mode and width, including zero, the most
    // negative number and the longest outputs.
    task automatic test_edge_values();
        send_request(MODE_SDEC, 1'b1, 64'd0);
        send_request(MODE_SDEC, 1'b1, 64'd1);
        send_request(MODE_SDEC, 1'b1, '1);
        send_request(MODE_SDEC, 1'b1, 64'h8000_0000_0000_0000);
        send_request(MODE_SDEC, 1'b1, 64'h7fff_ffff_ffff_ffff);
        send_request(MODE_SDEC, 1'b0, 64'hffff_ffff_0000_0000);
        send_request(MODE_SDEC, 1'b0, 64'h0123_4567_8000_0000);
        send_request(MODE_SDEC, 1'b0, 64'hffff_ffff_7fff_ffff);
        send_request(MODE_SDEC, 1'b0, 64'h0000_0000_ffff_ffff);
        send_request(MODE_UDEC, 1'b1, 64'd0);
        send_request(MODE_UDEC, 1'b1, '1);
        send_request(MODE_UDEC, 1'b1, 64'd10_000_000_000_000_000_000);
        send_request(MODE_UDEC, 1'b1, 64'd9);
        send_request(MODE_UDEC, 1'b0, '1);
        send_request(MODE_UDEC, 1'b0, 64'hffff_ffff_0000_0000);
        send_request(MODE_HEX,  1'b1, 64'd0);
        send_request(MODE_HEX,  1'b1, '1);
        send_request(MODE_HEX,  1'b1, 64'h0123_4567_89ab_cdef);
        send_request(MODE_HEX,  1'b1, 64'hfedc_ba98_7654_3210);
        send_request(MODE_HEX,  1'b0, 64'ha5a5_a5a5_dead_beef);
        send_request(MODE_HEX,  1'b0, 64'hffff_ffff_0000_0000);
        send_request(MODE_SPARE, 1'b1, 64'h1f);
        send_request(MODE_SPARE, 1'b0, 64'd0);
        send_request(MODE_SPARE, 1'b0, '1);
    endtask

    task automatic test_random_values(input int count);
        repeat (count)
            send_request(pick_mode(), 1'($urandom_range(1)), pick_value());
    endtask

    // Short burst, full drain with the request side held off, then restart.
    task automatic test_drained_restart();
        repeat (4)
            send_request(pick_mode(), 1'($urandom_range(1)), pick_value());
        drain_text();
        repeat (4)
            send_request(pick_mode(), 1'($urandom_range(1)), pick_value());
    endtask

    // Receiver: random back-pressure redrawn every cycle.
    always @(posedge clk)
        txt_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Character checker: compare each accepted character with the oldest
    // one owed.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && txt_valid && txt_ready)
        begin
            if (expected_text.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                          char_out, last));
            end
            else
            begin
                want = expected_text.pop_front();
                if (char_out !== want.ch)
                    report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                              char_out, want.ch));
                if (last !== want.fin)
                    report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
                                              last, want.fin, want.ch));
            end
            chars_checked++;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chars owed",
                     cycle_count, expected_text.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Light request gaps, heavy back-pressure.
        send_idle_pct = 6;
        recv_idle_pct = 82;
        test_edge_values();
        test_random_values(120);
        test_drained_restart();

        // Heavy request gaps, light back-pressure.
        send_idle_pct = 82;
        recv_idle_pct = 6;
        test_random_values(110);

        // Full rate both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_values(110);

        drain_text();
        repeat (END_GUARD) @(posedge clk);

        $display("%0d requests (sdec %0d, udec %0d, hex %0d, spare %0d), %0d chars checked",
                 requests_sent, mode_count[0], mode_count[1], mode_count[2],
                 mode_count[3], chars_checked);
        $display("edge values, shaped random values, drain pause, three idle mixes");
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
